[sv/iim_pkg.sv]
// Package for the interval insert-and-merge block.
// Holds the coordinate width and the beat and table entry types.
// No dependencies.
package iim_pkg;

  localparam int COORD_WIDTH = 32;

  typedef logic signed [COORD_WIDTH-1:0] coord_t;

  // One input beat: the range to insert.
  typedef struct packed {
    coord_t new_begin;
    coord_t new_end;
  } in_item_t;

  // One output beat: one stored range of the emitted table.
  typedef struct packed {
    coord_t out_begin;
    coord_t out_end;
    logic   last_range;
    logic   overflow;
  } out_item_t;

  // One table entry, low and high endpoint.
  typedef struct packed {
    coord_t lo;
    coord_t hi;
  } range_t;

endpackage

[sv/iim_table.sv]
// Range table storage for the interval insert-and-merge block.
// One write port and one read port with registered read data.
// Depends on iim_pkg for the entry type.
module iim_table #(
  parameter int DEPTH = 16
) (
  input  logic                       clk,
  input  logic                       wr_en,
  input  logic [$clog2(DEPTH)-1:0]   wr_addr,
  input  iim_pkg::range_t            wr_data,
  input  logic                       rd_en,
  input  logic [$clog2(DEPTH)-1:0]   rd_addr,
  output iim_pkg::range_t            rd_data
);

  iim_pkg::range_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

[sv/interval_insert_merge.sv]
// Top level of the interval insert-and-merge block.
// Depends on iim_pkg (types) and iim_table (range storage).
//
// Usage:
//   The block holds up to MAX_RANGES disjoint closed ranges and starts empty.
//   Each beat on the input channel (in_valid/in_ready, payload in_data) is a
//   new range; a reversed range is swapped so that begin never exceeds end.
//   Every stored range that overlaps or touches it is absorbed into it, the
//   survivors keep their order and the merged range goes after them. The
//   whole table then leaves on the output channel (out_valid/out_ready,
//   payload out_data), one beat per range, with last_range on the final beat.
//   If the table is full and nothing merges, the new range is dropped and
//   every beat of that table carries overflow.
//
// Sequence:
//   With N ranges stored before the insert and M after it, the sequencer
//   accepts the item in ST_IDLE, scans the N entries in ST_SCAN (one entry
//   per cycle through the single read port and one shared compare unit),
//   appends in ST_APPEND, starts the readback in ST_EMIT_START and emits
//   the M ranges in ST_EMIT. The input is ready only while the sequencer is
//   idle; the final result may still sit in the output register when the
//   next item is accepted.
//   A receiver stall freezes the readback; nothing is lost or repeated.
//   Reset empties the table and drops any pending output beat.
module interval_insert_merge #(
  parameter int MAX_RANGES = 16
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  iim_pkg::in_item_t   in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output iim_pkg::out_item_t  out_data
);

  localparam int IDX_W = $clog2(MAX_RANGES);
  localparam int CNT_W = $clog2(MAX_RANGES + 1);
  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_RANGES);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_APPEND,
    ST_EMIT_START,
    ST_EMIT
  } state_t;

  state_t             state;
  logic [CNT_W-1:0]   range_count;
  logic [CNT_W-1:0]   kept;
  logic [CNT_W-1:0]   proc_idx;
  logic [CNT_W-1:0]   emit_idx;
  logic               merged;
  logic               overflow_flag;
  iim_pkg::coord_t    nb;
  iim_pkg::coord_t    ne;

  // Table port signals.
  logic               rd_en;
  logic [IDX_W-1:0]   rd_addr;
  iim_pkg::range_t    rd_data;
  logic               wr_en;
  logic [IDX_W-1:0]   wr_addr;
  iim_pkg::range_t    wr_data;

  logic               disjoint;
  logic [CNT_W-1:0]   proc_next;
  logic [CNT_W-1:0]   emit_next;
  logic               emit_last;
  logic               append_drop;
  logic               out_free;
  logic               out_load;

  iim_table #(
    .DEPTH (MAX_RANGES)
  ) u_table (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  assign in_ready = (state == ST_IDLE);

  // The shared compare unit: the entry read last cycle against the growing
  // merged range. Touching endpoints count as overlap.
  assign disjoint    = (rd_data.lo > ne) || (rd_data.hi < nb);
  assign proc_next   = proc_idx + 1'b1;
  assign emit_next   = emit_idx + 1'b1;
  assign emit_last   = (emit_idx == range_count - 1'b1);
  assign append_drop = !merged && (range_count == CNT_MAX);
  assign out_free    = !out_valid || out_ready;
  // The output register takes a new beat whenever the readback may advance.
  assign out_load    = (state == ST_EMIT) && out_free;

  // Table control. Survivors are compacted in place: the write index never
  // passes the read index, so no entry is overwritten before it is read.
  always_comb begin
    rd_en   = 1'b0;
    rd_addr = '0;
    wr_en   = 1'b0;
    wr_addr = kept[IDX_W-1:0];
    wr_data = '{lo: nb, hi: ne};
    case (state)
      ST_IDLE: begin
        if (in_valid && (range_count != '0)) begin
          rd_en = 1'b1;
        end
      end
      ST_SCAN: begin
        if (disjoint) begin
          wr_en   = 1'b1;
          wr_data = rd_data;
        end
        if (proc_next < range_count) begin
          rd_en   = 1'b1;
          rd_addr = proc_next[IDX_W-1:0];
        end
      end
      ST_APPEND: begin
        wr_en = !append_drop;
      end
      ST_EMIT_START: begin
        rd_en = 1'b1;
      end
      ST_EMIT: begin
        if (out_free && !emit_last) begin
          rd_en   = 1'b1;
          rd_addr = emit_next[IDX_W-1:0];
        end
      end
      default: begin
        rd_en = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      range_count   <= '0;
      kept          <= '0;
      proc_idx      <= '0;
      emit_idx      <= '0;
      merged        <= 1'b0;
      overflow_flag <= 1'b0;
      out_valid     <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (in_valid) begin
            // A reversed range is swapped on the way in.
            if (in_data.new_end < in_data.new_begin) begin
              nb <= in_data.new_end;
              ne <= in_data.new_begin;
            end else begin
              nb <= in_data.new_begin;
              ne <= in_data.new_end;
            end
            merged   <= 1'b0;
            kept     <= '0;
            proc_idx <= '0;
            state    <= (range_count == '0) ? ST_APPEND : ST_SCAN;
          end
        end
        ST_SCAN: begin
          if (disjoint) begin
            kept <= kept + 1'b1;
          end else begin
            merged <= 1'b1;
            if (rd_data.lo < nb) begin
              nb <= rd_data.lo;
            end
            if (rd_data.hi > ne) begin
              ne <= rd_data.hi;
            end
          end
          proc_idx <= proc_next;
          if (proc_next == range_count) begin
            state <= ST_APPEND;
          end
        end
        ST_APPEND: begin
          overflow_flag <= append_drop;
          if (!append_drop) begin
            range_count <= kept + 1'b1;
          end
          state <= ST_EMIT_START;
        end
        ST_EMIT_START: begin
          emit_idx <= '0;
          state    <= ST_EMIT;
        end
        ST_EMIT: begin
          if (out_free) begin
            out_data <= '{out_begin:  rd_data.lo,
                          out_end:    rd_data.hi,
                          last_range: emit_last,
                          overflow:   overflow_flag};
            if (emit_last) begin
              state <= ST_IDLE;
            end else begin
              emit_idx <= emit_next;
            end
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

[sv/iim_checker.sv]
// Port-level checks for the interval insert-and-merge block.
// Depends on iim_pkg; bound to interval_insert_merge at the end of this file.
module iim_checker (
  input logic                clk,
  input logic                rst,
  input logic                in_valid,
  input logic                in_ready,
  input logic                out_valid,
  input logic                out_ready,
  input iim_pkg::out_item_t  out_data
);

  logic out_beat;
  logic mid_table;
  logic prev_ovf;

  assign out_beat = out_valid && out_ready;

  // Track whether the next output beat continues a table already started.
  always_ff @(posedge clk) begin
    if (rst) begin
      mid_table <= 1'b0;
      prev_ovf  <= 1'b0;
    end else if (out_beat) begin
      mid_table <= !out_data.last_range;
      prev_ovf  <= out_data.overflow;
    end
  end

  // An accepted range keeps the input closed for at least the next cycle.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("input ready right after an accepted beat");

  // While a table is still being emitted no new range is taken.
  a_closed_mid_table: assert property (@(posedge clk) disable iff (rst)
    (out_beat && !out_data.last_range) |-> !in_ready)
    else $error("input ready in the middle of a table");

  // The overflow mark is the same on every beat of one table.
  a_overflow_steady: assert property (@(posedge clk) disable iff (rst)
    (out_beat && mid_table) |-> (out_data.overflow == prev_ovf))
    else $error("overflow changed within a table");

  // Reset drops any pending output beat.
  a_reset_clears_out: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("output valid after reset");

endmodule

bind interval_insert_merge iim_checker u_iim_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

[verif/interval_insert_merge_test.sv]
// Self-checking testbench for interval_insert_merge: directed and random range inserts,
// with a local table model that predicts every emitted beat.
// Depends on iim_pkg (beat types) and the interval_insert_merge top level.
module interval_insert_merge_test;

  localparam int RANGE_SLOTS  = 16;
  localparam int RANDOM_ITEMS = 310;
  localparam int DRAIN_CYCLES = 2 * RANGE_SLOTS + 30;
  localparam int CYCLE_LIMIT  = 1000000;
  localparam int REPORT_LIMIT = 10;

  localparam iim_pkg::coord_t COORD_MIN = {1'b1, {(iim_pkg::COORD_WIDTH-1){1'b0}}};
  localparam iim_pkg::coord_t COORD_MAX = {1'b0, {(iim_pkg::COORD_WIDTH-1){1'b1}}};

  logic                clk;
  logic                rst = 1'b1;
  logic                in_valid = 1'b0;
  logic                in_ready;
  iim_pkg::in_item_t   in_data = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  iim_pkg::out_item_t  out_data;

  interval_insert_merge #(
    .MAX_RANGES(RANGE_SLOTS)
  ) DUT (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data(out_data)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Ranges waiting to be offered, and the table beats the block owes us.
  iim_pkg::in_item_t  pending_ranges[$];
  iim_pkg::out_item_t expected_beats[$];

  // Local copy of the range table, in the same order the block keeps it.
  iim_pkg::coord_t table_lo[RANGE_SLOTS];
  iim_pkg::coord_t table_hi[RANGE_SLOTS];
  int     table_count = 0;

  int  ranges_accepted = 0;
  int  beats_checked = 0;
  int  tables_seen = 0;
  int  overflow_tables = 0;
  int  widest_table = 0;
  int  mismatches = 0;
  int  cycle_count = 0;
  int  send_gap = 0;
  int  recv_gap = 0;
  bit  calm = 1'b0;
  int  window_base = 0;

  // Applies one insert to the local table and queues the beats of the
  // resulting table. Overlap includes endpoints that merely touch.
  function automatic void predict_insert(input iim_pkg::in_item_t item);
    iim_pkg::coord_t lo;
    iim_pkg::coord_t hi;
    iim_pkg::coord_t kept_lo[RANGE_SLOTS];
    iim_pkg::coord_t kept_hi[RANGE_SLOTS];
    int     kept;
    bit     absorbed;
    bit     dropped;
    iim_pkg::out_item_t beat;
    lo = item.new_begin;
    hi = item.new_end;
    kept = 0;
    absorbed = 1'b0;
    // A reversed range is taken with its endpoints swapped.
    if (hi < lo) begin
      lo = item.new_end;
      hi = item.new_begin;
    end
    for (int i = 0; i < table_count; i++) begin
      if (table_lo[i] > hi || table_hi[i] < lo) begin
        kept_lo[kept] = table_lo[i];
        kept_hi[kept] = table_hi[i];
        kept++;
      end else begin
        absorbed = 1'b1;
        if (table_lo[i] < lo) lo = table_lo[i];
        if (table_hi[i] > hi) hi = table_hi[i];
      end
    end
    // A full table with nothing to merge drops the new range.
    dropped = !absorbed && table_count >= RANGE_SLOTS;
    if (!dropped) begin
      for (int i = 0; i < kept; i++) begin
        table_lo[i] = kept_lo[i];
        table_hi[i] = kept_hi[i];
      end
      table_lo[kept] = lo;
      table_hi[kept] = hi;
      table_count = kept + 1;
    end
    if (table_count > widest_table) widest_table = table_count;
    for (int i = 0; i < table_count; i++) begin
      beat.out_begin  = table_lo[i];
      beat.out_end    = table_hi[i];
      beat.last_range = (i == table_count - 1);
      beat.overflow   = dropped;
      expected_beats = {expected_beats, beat};
    end
  endfunction

  // Idle length between beats: mostly none or short, now and then long.
  // In a calm stretch neither side idles at all.
  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (calm) return 0;
    if (roll < 55) return 0;
    else if (roll < 90) return $urandom_range(1, 3);
    else return $urandom_range(8, 30);
  endfunction

  function automatic iim_pkg::in_item_t make_range(input iim_pkg::coord_t lo,
                                                   input iim_pkg::coord_t hi);
    iim_pkg::in_item_t item;
    item.new_begin = lo;
    item.new_end   = hi;
    return item;
  endfunction

  // Adds one range to the end of the list of ranges to offer.
  function automatic void queue_range(input iim_pkg::coord_t lo,
                                      input iim_pkg::coord_t hi);
    pending_ranges = {pending_ranges, make_range(lo, hi)};
  endfunction

  // Random inserts. Most land in a narrow window around a moving base so
  // that the table fills, merges and overflows; a few are full-width random
  // values that exercise every coordinate bit, and a few span everything
  // so that the table collapses and can fill again.
  function automatic iim_pkg::in_item_t random_range(input int index);
    int     roll;
    int     lo;
    int     width;
    roll = $urandom_range(0, 99);
    if (index % 40 == 0) window_base = $urandom;
    if (roll < 8) begin
      return make_range(iim_pkg::coord_t'($urandom), iim_pkg::coord_t'($urandom));
    end else if (roll < 10) begin
      if ($urandom_range(0, 1)) return make_range(COORD_MIN, COORD_MAX);
      else return make_range(COORD_MAX, COORD_MIN);
    end else begin
      lo = window_base + int'($urandom_range(0, 400)) - 200;
      width = $urandom_range(0, 12);
      if ($urandom_range(0, 99) < 15)
        return make_range(iim_pkg::coord_t'(lo + width), iim_pkg::coord_t'(lo));
      else
        return make_range(iim_pkg::coord_t'(lo), iim_pkg::coord_t'(lo + width));
    end
  endfunction

  // Driver: offers the queued ranges one beat at a time. Valid is held with
  // a steady payload until the beat is taken; each accepted beat is fed to
  // the model at the edge where it was taken.
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      send_gap = 0;
    end else if (!(in_valid && !in_ready)) begin
      if (in_valid) begin
        predict_insert(in_data);
        ranges_accepted++;
        if ($urandom_range(0, 19) == 0) calm = ~calm;
      end
      if (send_gap > 0) begin
        send_gap--;
        in_valid <= 1'b0;
      end else if (pending_ranges.size() > 0) begin
        in_data  <= pending_ranges.pop_front();
        in_valid <= 1'b1;
        send_gap = pick_gap();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Monitor: takes output beats, compares them with the oldest prediction
  // and stalls the receiver at random points of the readback.
  always @(posedge clk) begin
    iim_pkg::out_item_t want;
    if (rst) begin
      out_ready <= 1'b0;
      recv_gap = 0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_beats.size() == 0) begin
          mismatches++;
          if (mismatches <= REPORT_LIMIT)
            $display("unexpected beat: begin %0d end %0d last %0b overflow %0b",
                     out_data.out_begin, out_data.out_end, out_data.last_range,
                     out_data.overflow);
        end else begin
          want = expected_beats.pop_front();
          beats_checked++;
          if (out_data.out_begin !== want.out_begin || out_data.out_end !== want.out_end ||
              out_data.last_range !== want.last_range ||
              out_data.overflow !== want.overflow) begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT)
              $display("beat %0d: want [%0d, %0d] last %0b ovf %0b, got [%0d, %0d] %0b %0b",
                       beats_checked, want.out_begin, want.out_end, want.last_range,
                       want.overflow, out_data.out_begin, out_data.out_end,
                       out_data.last_range, out_data.overflow);
          end
          if (want.last_range) begin
            tables_seen++;
            if (want.overflow) overflow_tables++;
          end
        end
      end
      if (recv_gap > 0) begin
        recv_gap--;
        out_ready <= 1'b0;
      end else if ($urandom_range(0, 3) == 0) begin
        recv_gap = pick_gap();
        out_ready <= (recv_gap == 0);
        if (recv_gap > 0) recv_gap--;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("run exceeded %0d cycles with %0d beats still owed",
               CYCLE_LIMIT, expected_beats.size());
      $display("status: fail");
      $finish;
    end
  end

  initial begin
    // Directed part: extreme coordinates, a reversed range, touching
    // endpoints, a full table that drops a disjoint range, a full table
    // that merges, and one range that swallows everything.
    queue_range(COORD_MIN, COORD_MIN);
    queue_range(COORD_MAX, COORD_MAX);
    queue_range(iim_pkg::coord_t'(10), iim_pkg::coord_t'(0));
    queue_range(iim_pkg::coord_t'(10), iim_pkg::coord_t'(20));
    queue_range(iim_pkg::coord_t'(-100), iim_pkg::coord_t'(-50));
    for (int k = 1; k <= 12; k++)
      queue_range(iim_pkg::coord_t'(100 * k), iim_pkg::coord_t'(100 * k + 5));
    queue_range(iim_pkg::coord_t'(50), iim_pkg::coord_t'(60));
    queue_range(COORD_MIN, iim_pkg::coord_t'(0));
    queue_range(COORD_MAX, COORD_MIN);
    queue_range(iim_pkg::coord_t'(-1), iim_pkg::coord_t'(-1));
    for (int n = 0; n < RANDOM_ITEMS; n++)
      pending_ranges = {pending_ranges, random_range(n)};

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Wait for every range to be taken and every table beat to arrive,
    // then give the block time to show any stray beat.
    while (pending_ranges.size() > 0 || in_valid || expected_beats.size() > 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (expected_beats.size() > 0)
      $display("%0d predicted beats never arrived", expected_beats.size());
    $display("inserted %0d ranges and checked %0d beats across %0d emitted tables",
             ranges_accepted, beats_checked, tables_seen);
    $display("%0d tables carried overflow; the table held up to %0d ranges",
             overflow_tables, widest_table);
    if (mismatches == 0 && expected_beats.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("%0d mismatching beats", mismatches);
      $display("status: fail");
    end
    $finish;
  end

endmodule
